// ----- src/mcw_pkg.sv -----
// ============================================================================
// mcw_pkg
// Shared types and constants for the multi-channel watchdog core.
// ============================================================================
package mcw_pkg;

    // Number of watchdog channels held in the table
    localparam int CHANNELS = 32;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int VAL_W    = 16;
    localparam int WORD_W   = 2 * VAL_W;

    localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

    typedef enum logic [1:0] {
        CMD_CHECK = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_FEED  = 2'd3
    } mcw_cmd_code_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FEED
    } mcw_state_t;

    typedef struct packed {
        mcw_cmd_code_t      command;
        logic [4:0]         channel;
        logic [VAL_W-1:0]   reload_value;
    } mcw_cmd_t;

    typedef struct packed {
        logic               check_ran;
        logic               all_fed;
        logic               timed_out;
        logic [4:0]         expired_channel;
    } mcw_result_t;

endpackage

// ----- src/mcw_ram.sv -----
// ============================================================================
// mcw_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module mcw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/multi_channel_watchdog_core.sv -----
// ============================================================================
// multi_channel_watchdog_core
// Software watchdog over a table of channels, each with a reload and a count.
// ============================================================================
// Usage:
//   Command channel: present an item on request and raise start; the item is
//   taken at a rising edge where start is high and busy is low.
//   Result channel: every item returns exactly one result on result, marked
//   by done for a single cycle. The receiver cannot stall; it must take the
//   result in that cycle.
//   Configuration: cfg_we writes cfg_wdata into the enable bit at any edge;
//   write it only while the core is idle.
// Completion:
//   start, stop, disabled check, out-of-range feed: result in the next cycle,
//   busy stays low. feed: the entry is read, then written in ST_FEED, then the
//   result is registered. enabled check: the scan walks one channel per
//   cycle through the table RAM's single read port and stops at the first
//   expired or last channel (CHANNELS = 32 here); busy is high during the scan.
// Reset:
//   Enable clears; per-entry valid bits clear so every channel reads as
//   reload zero, count zero. No clearing pass, the core is ready at once.
// ============================================================================
module multi_channel_watchdog_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  mcw_pkg::mcw_cmd_t   request,
    output logic                done,
    output mcw_pkg::mcw_result_t result,
    input  logic                cfg_we,
    input  logic                cfg_wdata
);
    import mcw_pkg::*;

    mcw_state_t         state_reg, state_next;
    logic [CH_W-1:0]    idx_reg, idx_next;
    logic [CHANNELS-1:0] valid_reg, valid_next;
    logic               enable_reg;
    logic               done_reg, done_next;
    mcw_result_t        result_reg, result_next;

    logic               accept;
    logic               in_range;
    logic [CH_W-1:0]    req_idx;
    logic               mem_we;
    logic [CH_W-1:0]    mem_waddr;
    logic [WORD_W-1:0]  mem_wdata;
    logic [WORD_W-1:0]  mem_rdata;
    logic [VAL_W-1:0]   entry_reload;
    logic [VAL_W-1:0]   entry_count;

    assign accept   = start && !busy;
    assign busy     = (state_reg != ST_IDLE);
    assign in_range = (32'(request.channel) < CHANNELS);
    assign req_idx  = CH_W'(request.channel);

    // Read data always belongs to idx_reg; an entry never written reads as zero
    assign entry_reload = valid_reg[idx_reg] ? mem_rdata[WORD_W-1:VAL_W] : '0;
    assign entry_count  = valid_reg[idx_reg] ? mem_rdata[VAL_W-1:0] : '0;

    mcw_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CHANNELS)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (idx_next),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            valid_reg  <= '0;
            enable_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                enable_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        valid_next  = valid_reg;
        done_next   = 1'b0;
        result_next = '0;
        mem_we      = 1'b0;
        mem_waddr   = idx_reg;
        mem_wdata   = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (request.command)
                        CMD_CHECK:
                        begin
                            if (enable_reg)
                            begin
                                idx_next   = '0;
                                state_next = ST_SCAN;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        CMD_START:
                        begin
                            done_next = 1'b1;
                            if (in_range)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = req_idx;
                                mem_wdata = {request.reload_value, request.reload_value};
                            end
                        end
                        CMD_STOP:
                        begin
                            done_next = 1'b1;
                            if (in_range)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = req_idx;
                                mem_wdata = '0;
                            end
                        end
                        CMD_FEED:
                        begin
                            if (in_range)
                            begin
                                idx_next   = req_idx;
                                state_next = ST_FEED;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (entry_reload != '0 && entry_count == '0)
                begin
                    // expired: stop here, leave this and later counts alone
                    done_next                   = 1'b1;
                    result_next.check_ran       = 1'b1;
                    result_next.timed_out       = 1'b1;
                    result_next.expired_channel = 5'(idx_reg);
                    state_next                  = ST_IDLE;
                end
                else
                begin
                    if (entry_reload != '0)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = idx_reg;
                        mem_wdata = {entry_reload, entry_count - 1'b1};
                    end
                    if (idx_reg == LAST_CH)
                    begin
                        done_next             = 1'b1;
                        result_next.check_ran = 1'b1;
                        result_next.all_fed   = 1'b1;
                        state_next            = ST_IDLE;
                    end
                    else
                    begin
                        // read the next channel while writing back this one
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_FEED:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                mem_wdata  = {entry_reload, entry_reload};
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (mem_we)
        begin
            valid_next[mem_waddr] = 1'b1;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef ASSERT_OFF
    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("result strobe outside idle state");

    a_scan_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (idx_reg <= LAST_CH))
        else $error("scan index beyond last channel");

    a_disabled_check: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && request.command == CMD_CHECK && !enable_reg)
        |=> (done_reg && !result_reg.check_ran))
        else $error("disabled check did not return an idle result");

    a_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (result_reg.check_ran == (result_reg.all_fed ^ result_reg.timed_out))
                     && !(result_reg.all_fed && result_reg.timed_out))
        else $error("inconsistent check outcome");

    a_start_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (request.command == CMD_START || request.command == CMD_STOP))
        |=> (done_reg && state_reg == ST_IDLE))
        else $error("start or stop did not complete in one cycle");
`endif

endmodule

// ----- bench/mcw_checker.sv -----
`timescale 1ns / 100ps
// ============================================================================
// mcw_checker
// Watches the command, result and enable ports of the watchdog core, keeps
// its own copy of the channel tables, predicts one result per accepted
// command and compares each strobed result field by field, in order.
// ============================================================================
module mcw_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  mcw_pkg::mcw_cmd_t    request,
    input  logic                 done,
    input  mcw_pkg::mcw_result_t result,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    output int                   mismatches,
    output int                   outstanding
);
    import mcw_pkg::*;

    logic [VAL_W-1:0] chan_reload [CHANNELS];
    logic [VAL_W-1:0] chan_count  [CHANNELS];
    logic             wd_enabled;
    mcw_result_t      pending_results[$];

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches = mismatches + 1;
    endtask

    // Update the channel tables for one command and return the result it yields.
    function automatic mcw_result_t apply_command(input mcw_cmd_t cmd);
        mcw_result_t res;
        bit          hit;
        res = '0;
        hit = 1'b0;
        case (cmd.command)
            CMD_CHECK:
                if (wd_enabled)
                begin
                    res.check_ran = 1'b1;
                    for (int idx = 0; idx < CHANNELS; idx++)
                    begin
                        if (!hit && chan_reload[idx] != '0)
                        begin
                            if (chan_count[idx] == '0)
                            begin
                                hit = 1'b1;
                                res.expired_channel = 5'(idx);
                            end
                            else
                                chan_count[idx] = chan_count[idx] - 1'b1;
                        end
                    end
                    res.timed_out = hit;
                    res.all_fed   = !hit;
                end
            CMD_START:
                if (int'(cmd.channel) < CHANNELS)
                begin
                    chan_reload[cmd.channel] = cmd.reload_value;
                    chan_count[cmd.channel]  = cmd.reload_value;
                end
            CMD_STOP:
                if (int'(cmd.channel) < CHANNELS)
                begin
                    chan_reload[cmd.channel] = '0;
                    chan_count[cmd.channel]  = '0;
                end
            CMD_FEED:
                if (int'(cmd.channel) < CHANNELS)
                    chan_count[cmd.channel] = chan_reload[cmd.channel];
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        mcw_result_t want;
        if (!rst_n)
        begin
            for (int idx = 0; idx < CHANNELS; idx++)
            begin
                chan_reload[idx] = '0;
                chan_count[idx]  = '0;
            end
            wd_enabled = 1'b0;
            pending_results.delete();
            outstanding = 0;
            mismatches  = 0;
        end
        else
        begin
            if (cfg_we)
                wd_enabled = cfg_wdata;
            // retire the oldest expectation before queuing a new one
            if (done)
            begin
                if (pending_results.size() == 0)
                    flag_mismatch("result with no command pending", 1, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (result.check_ran !== want.check_ran)
                        flag_mismatch("check_ran", result.check_ran, want.check_ran);
                    if (result.all_fed !== want.all_fed)
                        flag_mismatch("all_fed", result.all_fed, want.all_fed);
                    if (result.timed_out !== want.timed_out)
                        flag_mismatch("timed_out", result.timed_out, want.timed_out);
                    if (result.expired_channel !== want.expired_channel)
                        flag_mismatch("expired_channel", result.expired_channel,
                                      want.expired_channel);
                end
            end
            if (start && !busy)
                pending_results.push_back(apply_command(request));
            outstanding = pending_results.size();
        end
    end

endmodule

// ----- bench/multi_channel_watchdog_core_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// multi_channel_watchdog_core_tb
// Drives start, stop, feed and check commands into the watchdog core with
// random idle bursts, toggles the enable bit between phases, and leaves the
// prediction and comparison of every result to the checker.
// ============================================================================
module multi_channel_watchdog_core_tb;
    import mcw_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 2000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    mcw_cmd_t    request;
    logic        done;
    mcw_result_t result;
    logic        cfg_we;
    logic        cfg_wdata;
    int          mismatches;
    int          outstanding;
    int          stall_cycles;

    multi_channel_watchdog_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    mcw_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .done        (done),
        .result      (result),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // End the run if nothing moves on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Hold the item until the core takes it; leave start high for the caller
    task automatic send_item(input mcw_cmd_t item);
        start   <= 1'b1;
        request <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic issue(input mcw_cmd_code_t code, input int chan, input int reload);
        mcw_cmd_t item;
        item.command      = code;
        item.channel      = 5'(chan);
        item.reload_value = 16'(reload);
        send_item(item);
    endtask

    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_enable(input logic value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Small reloads and low channels keep timeouts frequent
    function automatic mcw_cmd_t random_command();
        mcw_cmd_t item;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 30)
            item.command = CMD_CHECK;
        else if (pick < 55)
            item.command = CMD_START;
        else if (pick < 65)
            item.command = CMD_STOP;
        else
            item.command = CMD_FEED;
        item.channel = ($urandom_range(99) < 70) ? 5'($urandom_range(7)) : 5'($urandom_range(31));
        pick = $urandom_range(99);
        if (item.command != CMD_START || pick >= 70)
            item.reload_value = 16'($urandom_range(65535));
        else if (pick < 15)
            item.reload_value = '0;
        else
            item.reload_value = 16'($urandom_range(1, 4));
        return item;
    endfunction

    task automatic random_phase(input int count, input bit with_gaps);
        for (int n = 0; n < count; n++)
        begin
            // idle only in some stretches of the phase
            if (with_gaps && (n % 100) < 60 && $urandom_range(3) == 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            send_item(random_command());
        end
    endtask

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        start     = 1'b0;
        request   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Disabled: checks must be ignored
        set_enable(1'b0);
        issue(CMD_CHECK, 0, 16'hFFFF);
        issue(CMD_START, 3, 2);
        issue(CMD_CHECK, 31, 0);

        set_enable(1'b1);
        issue(CMD_START, 0, 16'hFFFF);
        issue(CMD_START, 31, 1);
        issue(CMD_START, 5, 0);
        issue(CMD_FEED, 7, 16'hFFFF);
        issue(CMD_CHECK, 0, 0);
        issue(CMD_CHECK, 0, 0);
        issue(CMD_CHECK, 0, 0);
        issue(CMD_STOP, 3, 16'hFFFF);
        issue(CMD_CHECK, 0, 0);
        issue(CMD_FEED, 31, 0);
        issue(CMD_CHECK, 0, 0);
        issue(CMD_CHECK, 0, 0);
        issue(CMD_CHECK, 0, 0);
        issue(CMD_STOP, 0, 0);
        issue(CMD_STOP, 31, 0);
        issue(CMD_CHECK, 0, 0);
        issue(CMD_START, 1, 1);
        issue(CMD_CHECK, 0, 0);
        issue(CMD_CHECK, 0, 0);
        issue(CMD_CHECK, 0, 0);

        random_phase(400, 1'b1);
        set_enable(1'b0);
        random_phase(150, 1'b1);
        set_enable(1'b1);
        random_phase(400, 1'b1);
        drain();
        random_phase(150, 1'b0);

        drain();
        if (mismatches == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
